// ===== sv/drls_pkg.sv =====
// Shared types and constants for the digit roll-and-lock sequencer.
// Used by every module of the block; no dependencies.
package drls_pkg;

   localparam int LOCK_REGS    = 6;
   localparam int PACKED_TUBES = 6;
   localparam int CNT_W        = 16;

   localparam logic [3:0] BLANK_DIGIT = 4'd10;
   localparam logic [3:0] MAX_DIGIT   = 4'd9;

   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_START = 3'd1;
   localparam logic [2:0] OP_DOT   = 3'd2;
   localparam logic [2:0] OP_CLEAR = 3'd3;
   localparam logic [2:0] OP_DIGIT = 3'd4;

   localparam logic [1:0] EV_NONE    = 2'd0;
   localparam logic [1:0] EV_ROLL    = 2'd1;
   localparam logic [1:0] EV_LOCK    = 2'd2;
   localparam logic [1:0] EV_SETTLED = 2'd3;

   localparam logic [2:0] CSR_ROLL_INTERVAL = 3'd0;
   localparam logic [2:0] CSR_LOCK_BASE     = 3'd1;

   localparam logic [CNT_W-1:0] ROLL_INTERVAL_RST = 16'd50;
   localparam logic [CNT_W-1:0] LOCK_INTERVAL_RST = 16'd1000;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [2:0]  tube_index;
      logic        dot_on;
      logic [3:0]  digit_value;
      logic [23:0] random_digits;
   } item_type;

   typedef struct packed {
      logic [1:0]  event_code;
      logic        display_update;
      logic [23:0] shown_digits;
      logic [5:0]  shown_dots;
   } result_type;

   typedef struct packed {
      logic [CNT_W-1:0]                roll_interval;
      logic [LOCK_REGS-1:0][CNT_W-1:0] lock_interval;
   } cfg_type;

   typedef struct packed {
      logic       rolling;
      logic [2:0] lock_step;
   } status_type;

endpackage

// ===== sv/drls_csr.sv =====
// Configuration registers: roll interval and the per-step lock intervals.
// Depends on drls_pkg.
module drls_csr
   import drls_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff, cfg_in;
   logic [2:0] lock_idx;

   assign lock_idx = csr_addr - CSR_LOCK_BASE;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         if (csr_addr == CSR_ROLL_INTERVAL) begin
            cfg_in.roll_interval = csr_wdata;
         end else if (csr_addr >= CSR_LOCK_BASE &&
                      {1'b0, csr_addr} < 4'(int'(CSR_LOCK_BASE) + LOCK_REGS)) begin
            cfg_in.lock_interval[lock_idx] = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.roll_interval <= ROLL_INTERVAL_RST;
         for (int i = 0; i < LOCK_REGS; i++) begin
            cfg_ff.lock_interval[i] <= LOCK_INTERVAL_RST;
         end
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/drls_in_stage.sv =====
// Input register: captures one request transfer and holds it for the core.
// Depends on drls_pkg.
module drls_in_stage
   import drls_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic        pop,
   output logic        item_valid,
   output item_type    item
);

   logic     valid_ff, valid_in;
   item_type item_ff;
   logic     accept;

   assign req_tready = !valid_ff || pop;
   assign accept     = req_tvalid && req_tready;
   assign valid_in   = accept || (valid_ff && !pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.opcode        <= req_tuser;
         item_ff.tube_index    <= req_tdata[2:0];
         item_ff.dot_on        <= req_tdata[3];
         item_ff.digit_value   <= req_tdata[7:4];
         item_ff.random_digits <= req_tdata[31:8];
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== sv/drls_core.sv =====
// Sequencer state and the single-pass logic that turns one item into a result.
// Depends on drls_pkg; configuration comes from drls_csr.
module drls_core
   import drls_pkg::*;
#(
   parameter int TUBE_COUNT = 6
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type res,
   output status_type status
);

   localparam int SHOWN = (TUBE_COUNT < PACKED_TUBES) ? TUBE_COUNT : PACKED_TUBES;

   logic [TUBE_COUNT-1:0][3:0] true_ff, true_in;
   logic [TUBE_COUNT-1:0]      dots_ff, dots_in;
   logic [2:0]                 lock_step_ff, lock_step_in;
   logic                       rolling_ff, rolling_in;
   logic                       pending_ff, pending_in;
   logic [CNT_W-1:0]           roll_el_ff, roll_el_in;
   logic [CNT_W-1:0]           lock_el_ff, lock_el_in;

   logic [CNT_W-1:0] roll_sat, lock_sat, lock_limit;
   logic [2:0]       lock_sel, step_next;
   logic             settle;
   logic [3:0]       rnd_nib, digit_clamped;
   logic [23:0]      roll_view, true_view, blank_view;
   logic [5:0]       dot_view;

   assign roll_sat  = (roll_el_ff == '1) ? roll_el_ff : roll_el_ff + 1'b1;
   assign lock_sat  = (lock_el_ff == '1) ? lock_el_ff : lock_el_ff + 1'b1;
   assign lock_sel  = (lock_step_ff >= 3'(LOCK_REGS - 1)) ? 3'(LOCK_REGS - 1) : lock_step_ff;
   assign lock_limit = cfg.lock_interval[lock_sel];
   assign step_next = lock_step_ff + 3'd1;
   assign settle    = ({1'b0, step_next} >= 4'(TUBE_COUNT)) || (step_next == 3'd0);
   assign digit_clamped = (item.digit_value > BLANK_DIGIT) ? BLANK_DIGIT : item.digit_value;

   always_comb begin
      roll_view  = '0;
      true_view  = '0;
      blank_view = '0;
      dot_view   = '0;
      rnd_nib    = '0;
      for (int i = 0; i < SHOWN; i++) begin
         rnd_nib = item.random_digits[4*i +: 4];
         if (rnd_nib > MAX_DIGIT) begin
            rnd_nib = rnd_nib - BLANK_DIGIT;
         end
         roll_view[4*i +: 4]  = (3'(i) < lock_step_ff) ? true_ff[i] : rnd_nib;
         true_view[4*i +: 4]  = true_ff[i];
         blank_view[4*i +: 4] = BLANK_DIGIT;
         dot_view[i]          = dots_ff[i];
      end
   end

   always_comb begin
      true_in      = true_ff;
      dots_in      = dots_ff;
      lock_step_in = lock_step_ff;
      rolling_in   = rolling_ff;
      pending_in   = pending_ff;
      roll_el_in   = roll_el_ff;
      lock_el_in   = lock_el_ff;
      res          = '0;
      case (item.opcode)
         OP_TICK: begin
            roll_el_in = roll_sat;
            lock_el_in = lock_sat;
            if (rolling_ff) begin
               if (roll_sat >= cfg.roll_interval) begin
                  roll_el_in         = '0;
                  res.event_code     = EV_ROLL;
                  res.display_update = 1'b1;
                  res.shown_digits   = roll_view;
                  res.shown_dots     = dot_view;
               end
               if (lock_sat >= lock_limit) begin
                  lock_el_in   = '0;
                  pending_in   = 1'b1;
                  lock_step_in = step_next;
                  if (settle) begin
                     rolling_in     = 1'b0;
                     lock_step_in   = 3'd0;
                     res.event_code = EV_SETTLED;
                  end else begin
                     res.event_code = EV_LOCK;
                  end
               end
            end else if (pending_ff) begin
               pending_in         = 1'b0;
               res.display_update = 1'b1;
               res.shown_digits   = true_view;
               res.shown_dots     = dot_view;
            end
         end
         OP_START: begin
            lock_step_in = 3'd0;
            rolling_in   = 1'b1;
            roll_el_in   = '0;
            lock_el_in   = '0;
         end
         OP_DOT: begin
            for (int i = 0; i < TUBE_COUNT; i++) begin
               if (item.tube_index == 3'(i)) begin
                  dots_in[i] = item.dot_on;
                  pending_in = 1'b1;
               end
            end
         end
         OP_CLEAR: begin
            for (int i = 0; i < TUBE_COUNT; i++) begin
               true_in[i] = BLANK_DIGIT;
            end
            dots_in            = '0;
            res.display_update = 1'b1;
            res.shown_digits   = blank_view;
         end
         OP_DIGIT: begin
            for (int i = 0; i < TUBE_COUNT; i++) begin
               if (item.tube_index == 3'(i)) begin
                  true_in[i] = digit_clamped;
                  pending_in = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TUBE_COUNT; i++) begin
            true_ff[i] <= BLANK_DIGIT;
         end
         dots_ff      <= '0;
         lock_step_ff <= 3'd0;
         rolling_ff   <= 1'b0;
         pending_ff   <= 1'b0;
         roll_el_ff   <= '0;
         lock_el_ff   <= '0;
      end else if (fire) begin
         true_ff      <= true_in;
         dots_ff      <= dots_in;
         lock_step_ff <= lock_step_in;
         rolling_ff   <= rolling_in;
         pending_ff   <= pending_in;
         roll_el_ff   <= roll_el_in;
         lock_el_ff   <= lock_el_in;
      end
   end

   assign status.rolling   = rolling_ff;
   assign status.lock_step = lock_step_ff;

endmodule

// ===== sv/drls_out_stage.sv =====
// Result register: holds one result until the response transfer completes.
// Depends on drls_pkg.
module drls_out_stage
   import drls_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  result_type  res,
   output logic        can_load,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   output logic [2:0]  rsp_tuser
);

   logic       valid_ff, valid_in;
   result_type res_ff;

   assign can_load = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {2'b00, res_ff.shown_dots, res_ff.shown_digits};
   assign rsp_tuser  = {res_ff.display_update, res_ff.event_code};

endmodule

// ===== sv/digit_roll_lock_sequencer.sv =====
// Top level of the digit roll-and-lock sequencer.
// Depends on drls_pkg, drls_csr, drls_in_stage, drls_core, drls_out_stage.
//
// Takes one item per clock while the result side keeps draining, and returns
// exactly one result per item. Every item passes an input register, one pass of
// the sequencer logic and a result register; an item waits in the input register
// until the result register can load, and its result is held until the response
// transfer completes. Tick items advance the elapsed counters; roll and lock
// events come from comparing them with the interval registers. The user must
// write intervals on the csr port only while no item is in flight; the block does
// not enforce this. Index 0 is the roll interval, 1 to 6 the lock intervals.
module digit_roll_lock_sequencer
   import drls_pkg::*;
#(
   parameter int TUBE_COUNT = 6
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // tube_index[2:0], dot_on[3], digit_value[7:4],
                                    // random_digits[31:8]
   input  logic [2:0]  req_tuser,   // opcode[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // shown_digits[23:0], shown_dots[29:24], zero[31:30]
   output logic [2:0]  rsp_tuser,   // event_code[1:0], display_update[2]
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   cfg_type    cfg;
   item_type   item;
   result_type res;
   status_type status;
   logic       item_valid, can_load, fire;

   assign fire = item_valid && can_load;

   drls_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   drls_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .pop        (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   drls_core #(
      .TUBE_COUNT (TUBE_COUNT)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .cfg    (cfg),
      .res    (res),
      .status (status)
   );

   drls_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .res        (res),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   a_idle_step_zero : assert property (@(posedge clock) disable iff (reset)
      !status.rolling |-> status.lock_step == 3'd0)
      else $error("lock step nonzero while idle");

   a_step_in_range : assert property (@(posedge clock) disable iff (reset)
      {1'b0, status.lock_step} < 4'(TUBE_COUNT))
      else $error("lock step beyond tube count");

   a_no_push_no_data : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[2] |-> rsp_tdata == 32'd0)
      else $error("display data without update");

   a_roll_pushes : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == EV_ROLL |-> rsp_tuser[2])
      else $error("roll event without display update");

endmodule

// ===== tb/drls_display_check.sv =====
// Result checker for digit_roll_lock_sequencer: watches the req, rsp and csr ports,
// predicts every result from its own copy of the sequencer state and compares it.
// Depends on drls_pkg.
module drls_display_check
   import drls_pkg::*;
#(
   parameter int TUBES = 6
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata,
   output int          fails,
   output int          results_due
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [15:0] roll_ivl;
   logic [15:0] lock_ivl [LOCK_REGS];

   logic [3:0]  true_dig [8];
   logic        dot_flag [8];
   logic [3:0]  roll_dig [8];
   logic [2:0]  lock_step;
   logic        rolling;
   logic        change_pend;
   logic [15:0] roll_el;
   logic [15:0] lock_el;

   result_type  due_q [$];
   int          fail_cnt = 0;

   task automatic clear_model();
      int i;
      roll_ivl = ROLL_INTERVAL_RST;
      for (i = 0; i < LOCK_REGS; i++) lock_ivl[i] = LOCK_INTERVAL_RST;
      for (i = 0; i < 8; i++) begin
         true_dig[i] = BLANK_DIGIT;
         dot_flag[i] = 1'b0;
         roll_dig[i] = 4'd0;
      end
      lock_step   = 3'd0;
      rolling     = 1'b0;
      change_pend = 1'b0;
      roll_el     = '0;
      lock_el     = '0;
   endtask

   task automatic load_roll(input logic [23:0] rnd);
      int i;
      logic [3:0] d;
      for (i = 0; i < 8; i++) begin
         d = 4'd0;
         if (i < PACKED_TUBES) begin
            d = rnd[4*i +: 4];
            if (d > MAX_DIGIT) d = d - 4'd10;
         end
         roll_dig[i] = d;
      end
   endtask

   task automatic step_display(input item_type it, output result_type r);
      int i;
      logic [1:0] ev;
      logic       push;
      logic       from_roll;
      logic [2:0] li;
      ev = EV_NONE;
      push = 1'b0;
      from_roll = 1'b0;
      case (it.opcode)
         OP_TICK: begin
            if (roll_el != 16'hFFFF) roll_el++;
            if (lock_el != 16'hFFFF) lock_el++;
            if (rolling) begin
               li = (lock_step < LOCK_REGS) ? lock_step : 3'(LOCK_REGS - 1);
               if (roll_el >= roll_ivl) begin
                  load_roll(it.random_digits);
                  for (i = 0; i < lock_step; i++) roll_dig[i] = true_dig[i];
                  roll_el = '0;
                  from_roll = 1'b1;
                  push = 1'b1;
                  ev = EV_ROLL;
               end
               if (lock_el >= lock_ivl[li]) begin
                  lock_step = lock_step + 3'd1;
                  lock_el = '0;
                  change_pend = 1'b1;
                  if (lock_step >= TUBES || lock_step == 3'd0) begin
                     rolling = 1'b0;
                     lock_step = 3'd0;
                     ev = EV_SETTLED;
                  end else begin
                     ev = EV_LOCK;
                  end
               end
            end else if (change_pend) begin
               push = 1'b1;
               change_pend = 1'b0;
            end
         end
         OP_START: begin
            load_roll(it.random_digits);
            lock_step = 3'd0;
            rolling = 1'b1;
            roll_el = '0;
            lock_el = '0;
         end
         OP_DOT: begin
            if (it.tube_index < TUBES) begin
               dot_flag[it.tube_index] = it.dot_on;
               change_pend = 1'b1;
            end
         end
         OP_CLEAR: begin
            for (i = 0; i < 8; i++) begin
               true_dig[i] = BLANK_DIGIT;
               dot_flag[i] = 1'b0;
            end
            push = 1'b1;
         end
         OP_DIGIT: begin
            if (it.tube_index < TUBES) begin
               true_dig[it.tube_index] = (it.digit_value > BLANK_DIGIT) ? BLANK_DIGIT
                                                                       : it.digit_value;
               change_pend = 1'b1;
            end
         end
         default: ;
      endcase
      r = '0;
      r.event_code = ev;
      r.display_update = push;
      if (push) begin
         for (i = 0; i < TUBES && i < PACKED_TUBES; i++) begin
            r.shown_digits[4*i +: 4] = from_roll ? roll_dig[i] : true_dig[i];
            r.shown_dots[i] = dot_flag[i];
         end
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         fail_cnt++;
         $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      item_type   it;
      result_type want;
      result_type got;
      if (reset) begin
         clear_model();
         due_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_addr == CSR_ROLL_INTERVAL)
               roll_ivl = csr_wdata;
            else if (csr_addr >= CSR_LOCK_BASE && csr_addr < CSR_LOCK_BASE + LOCK_REGS)
               lock_ivl[csr_addr - CSR_LOCK_BASE] = csr_wdata;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.event_code     = rsp_tuser[1:0];
            got.display_update = rsp_tuser[2];
            got.shown_digits   = rsp_tdata[23:0];
            got.shown_dots     = rsp_tdata[29:24];
            if (due_q.size() == 0) begin
               fail_cnt++;
               $display("%0t: unexpected result: expected none, actual 0x%0h", $time, got);
            end else begin
               want = due_q.pop_front();
               check_field("event_code", want.event_code, got.event_code);
               check_field("display_update", want.display_update, got.display_update);
               check_field("shown_digits", want.shown_digits, got.shown_digits);
               check_field("shown_dots", want.shown_dots, got.shown_dots);
            end
         end
         if (req_tvalid && req_tready) begin
            it.opcode        = req_tuser;
            it.tube_index    = req_tdata[2:0];
            it.dot_on        = req_tdata[3];
            it.digit_value   = req_tdata[7:4];
            it.random_digits = req_tdata[31:8];
            step_display(it, want);
            due_q.push_back(want);
         end
      end
      fails       <= fail_cnt;
      results_due <= due_q.size();
   end

endmodule

// ===== tb/tb_top.sv =====
// Top of the digit_roll_lock_sequencer testbench: clock, reset, stimulus, csr setup
// and verdict. Depends on drls_pkg, the block itself and drls_display_check.
module tb_top;
   import drls_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TUBES = 6;
   localparam int LIMIT = 1_500_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [2:0]  req_tuser = OP_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = CSR_ROLL_INTERVAL;
   logic [15:0] csr_wdata = '0;

   int fails;
   int results_due;
   int cycles = 0;
   int sent = 0;

   always #4 clock = ~clock;

   digit_roll_lock_sequencer #(.TUBE_COUNT(TUBES)) DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   drls_display_check #(.TUBES(TUBES)) u_check (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .fails(fails), .results_due(results_due)
   );

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("digit_roll_lock_sequencer test failed");
         $finish;
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 30);
   endfunction

   // result side backpressure
   initial begin
      int g;
      @(posedge clock);
      forever begin
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         g = gap_len();
         if (g > 0) begin
            rsp_tready <= 1'b0;
            repeat (g) @(posedge clock);
         end
      end
   end

   function automatic item_type mk(logic [2:0] op, logic [2:0] idx, logic dot,
                                   logic [3:0] dig, logic [23:0] rnd);
      item_type it;
      it.opcode = op;
      it.tube_index = idx;
      it.dot_on = dot;
      it.digit_value = dig;
      it.random_digits = rnd;
      return it;
   endfunction

   function automatic item_type tick_item();
      return mk(OP_TICK, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                4'($urandom_range(0, 15)), 24'($urandom));
   endfunction

   function automatic item_type setup_item();
      item_type it;
      it = tick_item();
      it.opcode = ($urandom_range(0, 1) == 0) ? OP_DOT : OP_DIGIT;
      return it;
   endfunction

   function automatic item_type noise_item();
      item_type it;
      it = tick_item();
      case ($urandom_range(0, 9))
         0, 1: it.opcode = OP_DOT;
         2, 3: it.opcode = OP_DIGIT;
         4: it.opcode = OP_CLEAR;
         5: it.opcode = OP_START;
         6: it.opcode = OP_DIGIT + 3'($urandom_range(1, 3));
         default: it.opcode = OP_TICK;
      endcase
      return it;
   endfunction

   task automatic send(input item_type it);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.opcode;
      req_tdata  <= {it.random_digits, it.digit_value, it.dot_on, it.tube_index};
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_cfg(input cfg_type c);
      int i;
      csr_we    <= 1'b1;
      csr_addr  <= CSR_ROLL_INTERVAL;
      csr_wdata <= c.roll_interval;
      @(posedge clock);
      for (i = 0; i < LOCK_REGS; i++) begin
         csr_addr  <= CSR_LOCK_BASE + 3'(i);
         csr_wdata <= c.lock_interval[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   function automatic cfg_type fill_cfg(logic [15:0] roll, logic [15:0] lock);
      cfg_type c;
      c.roll_interval = roll;
      for (int i = 0; i < LOCK_REGS; i++) c.lock_interval[i] = lock;
      return c;
   endfunction

   function automatic logic [15:0] pick_interval(int hi, int odds);
      int r;
      r = $urandom_range(0, odds);
      if (r == 0) return '0;
      if (r == 1) return 16'hFFFF;
      return 16'($urandom_range(0, hi));
   endfunction

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.roll_interval = pick_interval(6, 8);
      for (int i = 0; i < LOCK_REGS; i++) c.lock_interval[i] = pick_interval(25, 25);
      return c;
   endfunction

   task automatic run_episode();
      repeat ($urandom_range(0, 4)) send(setup_item());
      send(mk(OP_START, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
              4'($urandom_range(0, 15)), 24'($urandom)));
      repeat ($urandom_range(5, 80)) begin
         if ($urandom_range(0, 9) < 8) send(tick_item());
         else send(noise_item());
      end
   endtask

   initial begin
      int target;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // power-on intervals: idle display handling
      send(mk(OP_TICK, 3'd0, 1'b0, 4'd0, 24'h000000));
      send(mk(OP_DIGIT, 3'd0, 1'b0, 4'd0, 24'h000000));
      send(mk(OP_DIGIT, 3'd5, 1'b0, MAX_DIGIT, 24'h000000));
      send(mk(OP_DIGIT, 3'd1, 1'b0, 4'd15, 24'h000000));
      send(mk(OP_DIGIT, 3'd2, 1'b0, BLANK_DIGIT, 24'h000000));
      send(mk(OP_DIGIT, 3'd7, 1'b1, 4'd3, 24'hFFFFFF));
      send(mk(OP_DOT, 3'd0, 1'b1, 4'd0, 24'h000000));
      send(mk(OP_DOT, 3'd5, 1'b1, 4'd0, 24'h000000));
      send(mk(OP_DOT, 3'd6, 1'b1, 4'd0, 24'h000000));
      send(mk(OP_DIGIT + 3'd1, 3'd7, 1'b1, 4'd15, 24'hFFFFFF));
      send(mk(OP_DIGIT + 3'd2, 3'd3, 1'b0, 4'd5, 24'($urandom)));
      send(mk(OP_DIGIT + 3'd3, 3'd4, 1'b1, 4'd9, 24'($urandom)));
      send(mk(OP_TICK, 3'd0, 1'b0, 4'd0, 24'h000000));
      send(mk(OP_TICK, 3'd0, 1'b0, 4'd0, 24'h000000));
      send(mk(OP_CLEAR, 3'd0, 1'b0, 4'd0, 24'h000000));
      send(mk(OP_DIGIT, 3'd3, 1'b0, 4'd7, 24'h000000));
      send(mk(OP_START, 3'd0, 1'b0, 4'd0, 24'hFFFFFF));
      send(mk(OP_TICK, 3'd0, 1'b0, 4'd0, 24'hFFFFFF));
      drain();

      // zero intervals: roll and lock on every tick, then settle
      write_cfg(fill_cfg(16'h0000, 16'h0000));
      send(mk(OP_START, 3'd0, 1'b0, 4'd0, 24'hA5F0C3));
      repeat (7) send(tick_item());
      drain();

      // lock with no roll expiry, restart while rolling
      write_cfg(fill_cfg(16'hFFFF, 16'h0001));
      send(mk(OP_START, 3'd0, 1'b0, 4'd0, 24'h123456));
      send(tick_item());
      send(mk(OP_START, 3'd0, 1'b0, 4'd0, 24'h987654));
      send(tick_item());
      send(tick_item());
      drain();

      repeat (6) begin
         write_cfg(random_cfg());
         target = sent + 200;
         while (sent < target) run_episode();
         drain();
      end

      repeat (8) @(posedge clock);
      if (fails == 0) begin
         $display("digit_roll_lock_sequencer test passed");
      end else begin
         $display("digit_roll_lock_sequencer test failed");
      end
      $finish;
   end

endmodule
